// ----- rtl/tosort_pkg.sv -----
// ----------------------------------------------------------------------------
// tosort_pkg
// Shared types, constants and the order-key function of the total-order sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package tosort_pkg;

	localparam int unsigned KEY_WIDTH = 64;
	localparam logic [KEY_WIDTH-1:0] SIGN_BIT = {1'b1, {(KEY_WIDTH-1){1'b0}}};

	// key_mode codes
	localparam logic MODE_INT   = 1'b0;
	localparam logic MODE_FLOAT = 1'b1;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic load;      // shift up, new word enters cell 0
		logic unload;    // shift down, cell 0 leaves
		logic sort_en;   // compare-exchange step
		logic phase;     // parity of the left cell of each pair
		logic key_mode;
	} cell_ctrl_t;

	// unsigned-comparable key: signed int or IEEE totalOrder
	function automatic logic [KEY_WIDTH-1:0] order_key(
		input logic [KEY_WIDTH-1:0] bits,
		input logic                 mode
	);
		logic [KEY_WIDTH-1:0] k;
		if (mode == MODE_FLOAT) begin
			k = bits[KEY_WIDTH-1] ? ~bits : (bits | SIGN_BIT);
		end else begin
			k = bits ^ SIGN_BIT;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/int_or_float_total_order_sorter.sv -----
// ----------------------------------------------------------------------------
// int_or_float_total_order_sorter
// Collects a set of 64-bit words in a chain of cells, sorts them in place by
// odd-even transposition, then streams them out in ascending order.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_stall    | element_bits, last_element
//   out     | out_valid / out_stall  | sorted_bits, last_of_run, dropped_any
//   cfg     | cfg_valid / cfg_ready  | key_mode
//
// A set of n words loads at one word per cycle, then sorts (one neighbor
// compare-exchange per cell per cycle), then unloads one word per accepted
// output cycle. Words beyond MAX_ELEMENTS are accepted and dropped. Input
// stalls outside the load phase. Reset clears control only; cell contents
// are don't-care.
// ----------------------------------------------------------------------------
`default_nettype none

module int_or_float_total_order_sorter #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [tosort_pkg::KEY_WIDTH-1:0] element_bits,
	input  wire                             last_element,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [tosort_pkg::KEY_WIDTH-1:0] sorted_bits,
	output logic                            last_of_run,
	output logic                            dropped_any,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire                             key_mode
);
	import tosort_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_SORT = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pass_q;
	logic          phase_q;
	logic          overflow_q;
	logic          key_mode_q;

	logic          in_acc;
	logic          out_acc;
	logic          full;
	logic [CW-1:0] count_inc;
	cell_ctrl_t    ctrl;

	logic [KEY_WIDTH-1:0] c_bits [MAX_ELEMENTS];
	logic [KEY_WIDTH-1:0] c_key  [MAX_ELEMENTS];
	logic                 c_swap [MAX_ELEMENTS];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_acc   = out_valid && !out_stall;
	assign full      = (count_q == FULL);
	assign count_inc = full ? count_q : count_q + CW'(1);

	assign sorted_bits = c_bits[0];
	assign last_of_run = (count_q == CW'(1));
	assign dropped_any = overflow_q;

	always_comb begin
		ctrl          = '0;
		ctrl.load     = in_acc && !full;
		ctrl.unload   = out_acc;
		ctrl.sort_en  = (state_q == S_SORT);
		ctrl.phase    = phase_q;
		ctrl.key_mode = key_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= MODE_INT;
		end else if (cfg_valid && cfg_ready) begin
			key_mode_q <= key_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			pass_q     <= '0;
			phase_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						count_q <= count_inc;
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (last_element) begin
							state_q <= S_SORT;
							pass_q  <= count_inc;
							phase_q <= 1'b0;
						end
					end
				end
				S_SORT: begin
					phase_q <= ~phase_q;
					if (pass_q <= CW'(1)) begin
						state_q <= S_OUT;
					end else begin
						pass_q <= pass_q - CW'(1);
					end
				end
				S_OUT: begin
					if (out_acc) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q    <= S_LOAD;
							overflow_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	genvar i;
	generate
		for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
			logic [KEY_WIDTH-1:0] lb, rb, rk;
			logic                 ls, pok;

			if (i == 0) begin : g_first
				assign lb = element_bits;
				assign ls = 1'b0;
			end else begin : g_mid
				assign lb = c_bits[i-1];
				assign ls = c_swap[i-1];
			end

			if (i == MAX_ELEMENTS - 1) begin : g_last
				assign rb  = '0;
				assign rk  = '0;
				assign pok = 1'b0;
			end else begin : g_inner
				assign rb  = c_bits[i+1];
				assign rk  = c_key[i+1];
				assign pok = (CW'(i + 1) < count_q);
			end

			tosort_cell #(
				.ODD(1'(i % 2))
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.left_bits (lb),
				.right_bits(rb),
				.right_key (rk),
				.left_swap (ls),
				.pair_ok   (pok),
				.bits      (c_bits[i]),
				.key       (c_key[i]),
				.swap      (c_swap[i])
			);
		end
	endgenerate

endmodule

`default_nettype wire

// ----- rtl/tosort_cell.sv -----
// ----------------------------------------------------------------------------
// tosort_cell
// One slot of the sorting chain: shifts up on load, down on unload, and does
// an odd-even compare-exchange with its right neighbor while sorting.
// ----------------------------------------------------------------------------
`default_nettype none

module tosort_cell #(
	parameter bit ODD = 1'b0
) (
	input  wire                             clk,
	input  wire  tosort_pkg::cell_ctrl_t    ctrl,
	input  wire  [tosort_pkg::KEY_WIDTH-1:0] left_bits,
	input  wire  [tosort_pkg::KEY_WIDTH-1:0] right_bits,
	input  wire  [tosort_pkg::KEY_WIDTH-1:0] right_key,
	input  wire                             left_swap,
	input  wire                             pair_ok,
	output logic [tosort_pkg::KEY_WIDTH-1:0] bits,
	output logic [tosort_pkg::KEY_WIDTH-1:0] key,
	output logic                            swap
);
	import tosort_pkg::*;

	logic [KEY_WIDTH-1:0] bits_q;
	logic                 left_role;

	assign bits      = bits_q;
	assign key       = order_key(bits_q, ctrl.key_mode);
	assign left_role = (ODD == ctrl.phase);
	assign swap      = ctrl.sort_en && left_role && pair_ok && (key > right_key);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bits_q <= left_bits;
		end else if (ctrl.unload) begin
			bits_q <= right_bits;
		end else if (ctrl.sort_en) begin
			if (swap) begin
				bits_q <= right_bits;
			end else if (!left_role && left_swap) begin
				bits_q <= left_bits;
			end
		end
	end

endmodule

`default_nettype wire
